>>> rtl/cgr_pkg.sv
// shared types, constants and row/column lookup for the covariance rotation block
// no dependencies
`default_nettype none

package cgr_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic [2:0] REG_PS_X = 3'd0;
  localparam logic [2:0] REG_PS_Y = 3'd1;
  localparam logic [2:0] REG_PS_Z = 3'd2;
  localparam logic [2:0] REG_VS_X = 3'd3;
  localparam logic [2:0] REG_VS_Y = 3'd4;
  localparam logic [2:0] REG_VS_Z = 3'd5;

  localparam logic [1:0] GRP_POS = 2'd0;
  localparam logic [1:0] GRP_CPL = 2'd1;
  localparam logic [1:0] GRP_VEL = 2'd2;

  localparam logic [2:0] FIRST_ROW = 3'd0;
  localparam logic [2:0] LAST_ROW  = 3'd5;

  localparam logic [62:0] SAT_POS = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] SAT_NEG = 63'h4000_0000_0000_0000;

  typedef struct packed {
    logic       zero;
    logic [1:0] grp;
    logic [2:0] pair;
  } cgr_sel_t;

  // values carried alongside the normalize / sqrt / divide pipeline
  typedef struct packed {
    logic [1:0][2:0][30:0] mn;
    logic [1:0][2:0]       ng;
    logic                  ok;
    logic [2:0][62:0]      da;
    logic [2:0][62:0]      db;
    logic [2:0][62:0]      dc;
  } cgr_carry_t;

  // index of an unordered pair of rotation rows
  function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] hi;
    logic [1:0] lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (hi == 2'd0) begin
      pair_idx = 3'd0;
    end else if (hi == 2'd1) begin
      pair_idx = 3'd1 + {1'b0, lo};
    end else begin
      pair_idx = 3'd3 + {1'b0, lo};
    end
  endfunction

  // which precomputed entry lands at (row, col)
  function automatic cgr_sel_t ent_sel(input logic [2:0] row, input logic [2:0] col);
    cgr_sel_t s;
    s.zero = (col > row);
    if (row < 3'd3) begin
      s.grp  = GRP_POS;
      s.pair = pair_idx(row[1:0], col[1:0]);
    end else if (col < 3'd3) begin
      s.grp  = GRP_CPL;
      s.pair = pair_idx(2'(row - 3'd3), col[1:0]);
    end else begin
      s.grp  = GRP_VEL;
      s.pair = pair_idx(2'(row - 3'd3), 2'(col - 3'd3));
    end
    ent_sel = s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cgr_wmul.sv
// two-stage unsigned 64x64 multiplier built from four 32x32 partial products
// optional negate of the result; no package dependencies
`default_nettype none

module cgr_wmul (
  input  wire logic                clk,
  input  wire logic [63:0]         a,
  input  wire logic [63:0]         b,
  input  wire logic                neg,
  output logic signed [127:0]      p
);

  logic [63:0]  pp00;
  logic [63:0]  pp01;
  logic [63:0]  pp10;
  logic [63:0]  pp11;
  logic         neg1;
  logic [127:0] sum;

  always_ff @(posedge clk) begin
    pp00 <= a[31:0]  * b[31:0];
    pp01 <= a[31:0]  * b[63:32];
    pp10 <= a[63:32] * b[31:0];
    pp11 <= a[63:32] * b[63:32];
    neg1 <= neg;
  end

  assign sum = {64'd0, pp00} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0} + {pp11, 64'd0};

  always_ff @(posedge clk) begin
    p <= neg1 ? -$signed(sum) : $signed(sum);
  end

endmodule

`default_nettype wire

>>> rtl/covariance_grow_rotate_rtn.sv
// covariance growth and ecef-to-rtn rotation, top level
// uses cgr_pkg and cgr_wmul
// row 0 reaches the result ports once the request leaves the datapath, and rows 1..5 follow
// in order; a request is accepted only while not busy, so the six-row outputs never overlap
// busy is high while the pace counter runs down; the 79-stage datapath holds many requests
// rst clears valid bits, busy counter, row sequencer, output strobe and the six sigma registers
`default_nettype none

module covariance_grow_rotate_rtn import cgr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic [27:0]        elapsed,
  output logic                    strobe,
  output logic [2:0]              row_index,
  output logic signed [62:0]      elem0,
  output logic signed [62:0]      elem1,
  output logic signed [62:0]      elem2,
  output logic signed [62:0]      elem3,
  output logic signed [62:0]      elem4,
  output logic signed [62:0]      elem5,
  output logic                    degenerate,
  output logic                    last_row,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // stage numbering: stage 1 is the capture register, and each stage is one register after the one before
  localparam int CY0     = 6;                    // carry line starts here
  localparam int ST_SQ0  = 8;                    // sum of squares ready
  localparam int ST_N    = ST_SQ0 + SQRT_STEPS;  // norm ready
  localparam int ST_D0   = ST_N + 1;             // dividends loaded
  localparam int ST_Q    = ST_D0 + DIV_STEPS;    // unit components ready
  localparam int ST_T    = ST_Q + 1;             // T cross products
  localparam int ST_QM   = ST_Q + 2;             // full rotation
  localparam int ST_PP   = ST_Q + 3;             // row pair products
  localparam int ST_SUM  = ST_PP + 3;            // three-term sums
  localparam int ST_ENT  = ST_SUM + 1;           // rounded entries
  localparam int CY_LEN  = ST_SUM - CY0;

  // ---------------------------------------------------------------- config port
  logic [23:0] ps_cfg [3];
  logic [19:0] vs_cfg [3];
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        ps_cfg[k] <= '0;
        vs_cfg[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PS_X: ps_cfg[0] <= pwdata[23:0];
        REG_PS_Y: ps_cfg[1] <= pwdata[23:0];
        REG_PS_Z: ps_cfg[2] <= pwdata[23:0];
        REG_VS_X: vs_cfg[0] <= pwdata[19:0];
        REG_VS_Y: vs_cfg[1] <= pwdata[19:0];
        REG_VS_Z: vs_cfg[2] <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PS_X: prdata = {8'd0, ps_cfg[0]};
      REG_PS_Y: prdata = {8'd0, ps_cfg[1]};
      REG_PS_Z: prdata = {8'd0, ps_cfg[2]};
      REG_VS_X: prdata = {12'd0, vs_cfg[0]};
      REG_VS_Y: prdata = {12'd0, vs_cfg[1]};
      REG_VS_Z: prdata = {12'd0, vs_cfg[2]};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- request pacing
  // a new request is held off while busy so the output rows never overlap
  logic [2:0] pace;
  logic       accept;

  assign busy   = (pace != 3'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pace <= '0;
    end else if (accept) begin
      pace <= LAST_ROW;
    end else if (pace != 3'd0) begin
      pace <= pace - 3'd1;
    end
  end

  // valid bits that travel with the data
  logic [ST_ENT:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST_ENT-1:1], accept};
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic signed [31:0] r1 [3];
  logic signed [31:0] v1 [3];
  logic [27:0]        dt1;

  always_ff @(posedge clk) begin
    if (accept) begin
      r1[0] <= pos_x;
      r1[1] <= pos_y;
      r1[2] <= pos_z;
      v1[0] <= vel_x;
      v1[1] <= vel_y;
      v1[2] <= vel_z;
      dt1   <= elapsed;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic signed [63:0] cp2 [6];
  logic signed [31:0] r2 [3];
  logic [55:0]        dtsq2;
  logic [27:0]        dt2;
  logic [39:0]        sv2_2 [3];
  logic [47:0]        ps2_2 [3];

  always_ff @(posedge clk) begin
    cp2[0] <= r1[1] * v1[2];
    cp2[1] <= r1[2] * v1[1];
    cp2[2] <= r1[2] * v1[0];
    cp2[3] <= r1[0] * v1[2];
    cp2[4] <= r1[0] * v1[1];
    cp2[5] <= r1[1] * v1[0];
    dtsq2  <= dt1 * dt1;
    dt2    <= dt1;
    for (int k = 0; k < 3; k++) begin
      r2[k]    <= r1[k];
      sv2_2[k] <= vs_cfg[k] * vs_cfg[k];
      ps2_2[k] <= ps_cfg[k] * ps_cfg[k];
    end
  end

  // drift growth products, ready at stage 4
  logic signed [127:0] gp4 [3];
  logic signed [127:0] cp4 [3];

  for (genvar k = 0; k < 3; k++) begin : g_drift
    cgr_wmul u_grow (
      .clk (clk),
      .a   ({8'd0, dtsq2}),
      .b   ({24'd0, sv2_2[k]}),
      .neg (1'b0),
      .p   (gp4[k])
    );
    cgr_wmul u_cpl (
      .clk (clk),
      .a   ({36'd0, dt2}),
      .b   ({24'd0, sv2_2[k]}),
      .neg (1'b0),
      .p   (cp4[k])
    );
  end

  // ---------------------------------------------------------------- stage 3: angular momentum
  logic signed [63:0] h3 [3];
  logic signed [31:0] r3 [3];
  logic [39:0]        sv2_3 [3];
  logic [47:0]        ps2_3 [3];

  always_ff @(posedge clk) begin
    h3[0] <= cp2[0] - cp2[1];
    h3[1] <= cp2[2] - cp2[3];
    h3[2] <= cp2[4] - cp2[5];
    for (int k = 0; k < 3; k++) begin
      r3[k]    <= r2[k];
      sv2_3[k] <= sv2_2[k];
      ps2_3[k] <= ps2_2[k];
    end
  end

  // ---------------------------------------------------------------- stage 4: magnitudes
  // lane 0 is the radial vector, lane 1 the angular momentum
  logic [63:0] m4 [2][3];
  logic        ng4 [2][3];
  logic [39:0] sv2_4 [3];
  logic [47:0] ps2_4 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m4[0][k]  <= {32'd0, r3[k][31] ? (~r3[k] + 32'd1) : r3[k]};
      ng4[0][k] <= r3[k][31];
      m4[1][k]  <= h3[k][63] ? (~h3[k] + 64'd1) : h3[k];
      ng4[1][k] <= h3[k][63];
      sv2_4[k]  <= sv2_3[k];
      ps2_4[k]  <= ps2_3[k];
    end
  end

  // ---------------------------------------------------------------- stage 5: leading one, diag terms
  function automatic logic [5:0] msb64(input logic [63:0] x);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) pos = 6'(i);
    end
    msb64 = pos;
  endfunction

  logic [63:0] m5 [2][3];
  logic        ng5 [2][3];
  logic [5:0]  pos5 [2];
  logic        nz5 [2];
  logic [62:0] da5 [3];
  logic [62:0] db5 [3];
  logic [62:0] dc5 [3];

  logic [127:0] gr [3];
  logic [62:0]  gx [3];
  logic [63:0]  xs [3];
  logic [40:0]  dbr [3];
  logic [127:0] dcr [3];

  // position variance: ps^2 plus rounded dt^2 vs^2 / 2^24, saturated twice; vs^2 and dt vs^2 rounded too
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gr[k]  = (gp4[k] + 128'd8388608) >> 24;
      gx[k]  = (gr[k] > {65'd0, SAT_POS}) ? SAT_POS : gr[k][62:0];
      xs[k]  = {1'b0, gx[k]} + {16'd0, ps2_4[k]};
      dbr[k] = {1'b0, sv2_4[k]} + 41'd32768;
      dcr[k] = cp4[k] + 128'd524288;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      pos5[l] <= msb64(m4[l][0] | m4[l][1] | m4[l][2]);
      nz5[l]  <= (m4[l][0] | m4[l][1] | m4[l][2]) != 64'd0;
      for (int k = 0; k < 3; k++) begin
        m5[l][k]  <= m4[l][k];
        ng5[l][k] <= ng4[l][k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      da5[k] <= (xs[k] > {1'b0, SAT_POS}) ? SAT_POS : xs[k][62:0];
      db5[k] <= {38'd0, dbr[k][40:16]};
      dc5[k] <= {15'd0, dcr[k][67:20]};
    end
  end

  // ---------------------------------------------------------------- stage 6: normalize into carry line
  cgr_carry_t cy [0:CY_LEN];
  cgr_carry_t cy_in;

  always_comb begin
    cy_in = '0;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        // largest magnitude lands in [2^30, 2^31)
        if (pos5[l] > 6'd30) begin
          cy_in.mn[l][k] = 31'(m5[l][k] >> (pos5[l] - 6'd30));
        end else begin
          cy_in.mn[l][k] = 31'(m5[l][k] << (6'd30 - pos5[l]));
        end
        cy_in.ng[l][k] = ng5[l][k];
      end
    end
    cy_in.ok = nz5[0] && nz5[1];
    for (int k = 0; k < 3; k++) begin
      cy_in.da[k] = da5[k];
      cy_in.db[k] = db5[k];
      cy_in.dc[k] = dc5[k];
    end
  end

  always_ff @(posedge clk) begin
    cy[0] <= cy_in;
    for (int i = 1; i <= CY_LEN; i++) begin
      cy[i] <= cy[i-1];
    end
  end

  // ---------------------------------------------------------------- stages 7-8: sum of squares
  // then the square root, one bit a stage
  logic [61:0] sq7 [2][3];
  logic [31:0] sr [0:SQRT_STEPS][2];
  logic [63:0] ss [0:SQRT_STEPS][2];
  logic [31:0] sq_cand [SQRT_STEPS][2];

  always_comb begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      for (int l = 0; l < 2; l++) begin
        sq_cand[i][l] = sr[i][l] | (32'd1 << (SQRT_STEPS - 1 - i));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        sq7[l][k] <= cy[0].mn[l][k] * cy[0].mn[l][k];
      end
      ss[0][l] <= {2'd0, sq7[l][0]} + {2'd0, sq7[l][1]} + {2'd0, sq7[l][2]};
      sr[0][l] <= '0;
    end
    for (int i = 0; i < SQRT_STEPS; i++) begin
      for (int l = 0; l < 2; l++) begin
        ss[i+1][l] <= ss[i][l];
        if (64'(sq_cand[i][l] * sq_cand[i][l]) <= ss[i][l]) begin
          sr[i+1][l] <= sq_cand[i][l];
        end else begin
          sr[i+1][l] <= sr[i][l];
        end
      end
    end
  end

  // ---------------------------------------------------------------- rounded divide, one bit a stage
  logic [61:0] dn [0:DIV_STEPS][2][3];
  logic [31:0] dv [0:DIV_STEPS][2];
  logic [30:0] dq [0:DIV_STEPS][2][3];
  logic [30:0] dq_cand [DIV_STEPS][2][3];
  // the dividend is loaded as mn * 2^30; the half-divisor is added on the first step
  logic [61:0] dn0_fix [2][3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        dn0_fix[l][k] = dn[0][l][k] + {31'd0, dv[0][l][31:1]};
      end
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          dq_cand[i][l][k] = dq[i][l][k] | (31'd1 << (DIV_STEPS - 1 - i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      dv[0][l] <= sr[SQRT_STEPS][l];
      for (int k = 0; k < 3; k++) begin
        dn[0][l][k] <= {1'b0, cy[ST_N-CY0].mn[l][k], 30'd0};
        dq[0][l][k] <= '0;
      end
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      for (int l = 0; l < 2; l++) begin
        dv[i+1][l] <= dv[i][l];
        for (int k = 0; k < 3; k++) begin
          dn[i+1][l][k] <= (i == 0) ? dn0_fix[l][k] : dn[i][l][k];
          if (64'(dq_cand[i][l][k] * dv[i][l]) <=
              {2'd0, ((i == 0) ? dn0_fix[l][k] : dn[i][l][k])}) begin
            dq[i+1][l][k] <= dq_cand[i][l][k];
          end else begin
            dq[i+1][l][k] <= dq[i][l][k];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- signed unit vectors, T products
  logic signed [31:0] uq [2][3];
  logic signed [63:0] tp73 [6];
  logic signed [31:0] ur73 [3];
  logic signed [31:0] un73 [3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        uq[l][k] = cy[ST_Q-CY0].ng[l][k] ? -$signed({1'b0, dq[DIV_STEPS][l][k]})
                                         :  $signed({1'b0, dq[DIV_STEPS][l][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    tp73[0] <= uq[1][1] * uq[0][2];
    tp73[1] <= uq[1][2] * uq[0][1];
    tp73[2] <= uq[1][2] * uq[0][0];
    tp73[3] <= uq[1][0] * uq[0][2];
    tp73[4] <= uq[1][0] * uq[0][1];
    tp73[5] <= uq[1][1] * uq[0][0];
    for (int k = 0; k < 3; k++) begin
      ur73[k] <= uq[0][k];
      un73[k] <= uq[1][k];
    end
  end

  // ---------------------------------------------------------------- full rotation rows R T N
  logic signed [63:0] tx [3];
  logic [63:0]        tm [3];
  logic [63:0]        tr [3];
  logic signed [33:0] qm74 [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tx[k] = tp73[2*k] - tp73[2*k+1];
      tm[k] = tx[k][63] ? (~tx[k] + 64'd1) : tx[k];
      tr[k] = (tm[k] + 64'd536870912) >> 30;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      qm74[0][k] <= 34'(ur73[k]);
      qm74[2][k] <= 34'(un73[k]);
      qm74[1][k] <= tx[k][63] ? -$signed(tr[k][33:0]) : $signed(tr[k][33:0]);
    end
  end

  // ---------------------------------------------------------------- pair products
  logic signed [67:0] pq [6][3];
  logic [63:0]        pm75 [6][3];
  logic               pn75 [6][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b <= a; b++) begin
        for (int k = 0; k < 3; k++) begin
          pq[pair_idx(2'(a), 2'(b))][k] = qm74[a][k] * qm74[b][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 3; k++) begin
        pm75[p][k] <= pq[p][k][67] ? 64'(~pq[p][k] + 68'd1) : pq[p][k][63:0];
        pn75[p][k] <= pq[p][k][67];
      end
    end
  end

  // ---------------------------------------------------------------- scaled by diagonal terms
  logic signed [127:0] wp [3][6][3];

  for (genvar g = 0; g < 3; g++) begin : g_grp
    for (genvar p = 0; p < 6; p++) begin : g_pair
      for (genvar k = 0; k < 3; k++) begin : g_axis
        cgr_wmul u_term (
          .clk (clk),
          .a   (pm75[p][k]),
          .b   ({1'b0, (g == 0) ? cy[ST_PP-CY0].da[k]
                       : (g == 1) ? cy[ST_PP-CY0].dc[k] : cy[ST_PP-CY0].db[k]}),
          .neg (pn75[p][k]),
          .p   (wp[g][p][k])
        );
      end
    end
  end

  // ---------------------------------------------------------------- sum, round, saturate
  logic signed [127:0] es78 [3][6];
  logic [62:0]         ent79 [3][6];
  logic                ok79;
  logic [127:0]        emag [3][6];
  logic [67:0]         erd [3][6];
  logic [62:0]         elim [3][6];
  logic [62:0]         esat [3][6];

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      for (int p = 0; p < 6; p++) begin
        es78[g][p] <= wp[g][p][0] + wp[g][p][1] + wp[g][p][2];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int p = 0; p < 6; p++) begin
        emag[g][p] = es78[g][p][127] ? (~es78[g][p] + 128'd1) : es78[g][p];
        erd[g][p]  = 68'((emag[g][p] + 128'h0800_0000_0000_0000) >> 60);
        elim[g][p] = es78[g][p][127] ? SAT_NEG : SAT_POS;
        esat[g][p] = (erd[g][p] > {5'd0, elim[g][p]}) ? elim[g][p] : erd[g][p][62:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ok79 <= cy[ST_SUM-CY0].ok;
    for (int g = 0; g < 3; g++) begin
      for (int p = 0; p < 6; p++) begin
        if (!cy[ST_SUM-CY0].ok) begin
          ent79[g][p] <= '0;
        end else begin
          ent79[g][p] <= es78[g][p][127] ? (~esat[g][p] + 63'd1) : esat[g][p];
        end
      end
    end
  end

  // ---------------------------------------------------------------- row sequencer
  logic [62:0] ebuf [3][6];
  logic        bok;
  logic [2:0]  row;
  logic        act;
  cgr_sel_t    sel [6];
  logic [62:0] elem_next [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      row <= FIRST_ROW;
    end else if (vld[ST_ENT]) begin
      act <= 1'b1;
      row <= FIRST_ROW;
    end else if (act) begin
      row <= row + 3'd1;
      if (row == LAST_ROW) begin
        act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld[ST_ENT]) begin
      ebuf <= ent79;
      bok  <= ok79;
    end
  end

  // lower-triangle lookup for the row being sent
  always_comb begin
    for (int c = 0; c < 6; c++) begin
      sel[c]       = ent_sel(row, 3'(c));
      elem_next[c] = sel[c].zero ? 63'd0 : ebuf[sel[c].grp][sel[c].pair];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      row_index  <= row;
      elem0      <= elem_next[0];
      elem1      <= elem_next[1];
      elem2      <= elem_next[2];
      elem3      <= elem_next[3];
      elem4      <= elem_next[4];
      elem5      <= elem_next[5];
      degenerate <= !bok;
      last_row   <= (row == LAST_ROW);
    end
  end

endmodule

`default_nettype wire
